FILE: hw/rtl/asrb_pkg.sv
// ----------------------------------------------------------------------------
// asrb_pkg: shared types and constants of the acked sequence ring buffer
// Sizes, operation codes and the control structs between top and compactor.
// ----------------------------------------------------------------------------
package asrb_pkg;

   // ring depth, a power of two so that ring arithmetic wraps by truncation
   localparam int DEPTH        = 32;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int SEQ_W        = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int HELD_W       = 6;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_DROP   = 2'd1;
   localparam logic [1:0] OP_REPLAY = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]        seq;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // command from the top level sequencer to the compactor
   typedef struct packed {
      logic             push;
      logic             drop;
      logic             read;
      logic [IDX_W-1:0] addr;
      logic [CNT_W-1:0] count;
      logic [SEQ_W-1:0] ack;
      entry_type        entry;
   } cmd_type;

   // compactor status
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] kept;
   } walk_type;

endpackage

FILE: hw/rtl/acked_sequence_ring_buffer.sv
// ----------------------------------------------------------------------------
// acked_sequence_ring_buffer: retransmit ring with serial-number acknowledge
// Requests enter on req_*, results leave on rsp_*.
// ----------------------------------------------------------------------------
// Request: tuser = operation (push, drop acknowledged, drop then replay);
// tdata = push_seq, push_payload, ack_seq from the lowest bit up.
// Result: tuser = entry_valid, tlast = last, tdata = entry_seq,
// entry_payload, held_count from the lowest bit up.
// A push writes at the head and gives one status result in the next cycle;
// a full ring overwrites its oldest entry. A drop walks the n held entries
// one a cycle through a single 16-bit serial compare and packs the kept ones,
// then gives one status result. A drop with replay then reads the kept
// entries back one at a time through the registered store port, in a read
// state then a load state, one result each with tlast on the final one.
// req_tready is high only while the sequencer is idle and the output
// register is free or being taken; a stalled receiver holds the result and
// the sequencer waits. Reset empties the ring; stored entries need no clear.
// ----------------------------------------------------------------------------
module acked_sequence_ring_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // push_seq[15:0], push_payload[47:16], ack_seq[63:48]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // entry_seq[15:0], entry_payload[47:16],
                                    // held_count[53:48], zero[55:54]
   output logic        rsp_tuser,   // entry_valid
   output logic        rsp_tlast    // last
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DROP   = 3'd1;
   localparam logic [2:0] ST_STATUS = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [asrb_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [asrb_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [asrb_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic                          replay_ff, replay_in;

   logic                             out_valid_ff, out_valid_in;
   logic                             out_user_ff, out_user_in;
   logic                             out_last_ff, out_last_in;
   logic [asrb_pkg::SEQ_W-1:0]        out_seq_ff, out_seq_in;
   logic [asrb_pkg::PAYLOAD_BITS-1:0] out_pay_ff, out_pay_in;
   logic [asrb_pkg::HELD_W-1:0]       out_held_ff, out_held_in;

   asrb_pkg::cmd_type                 cmd;
   asrb_pkg::walk_type                walk;
   logic [asrb_pkg::SEQ_W-1:0]        rd_seq;
   logic [asrb_pkg::PAYLOAD_BITS-1:0] rd_payload;

   logic                       out_free;
   logic                       req_fire;
   logic                       last_entry;
   logic [asrb_pkg::IDX_W-1:0] start;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   // oldest held entry
   assign start      = head_ff - count_ff[asrb_pkg::IDX_W-1:0];
   assign last_entry = (idx_ff + 1'b1) == count_ff;

   asrb_compactor u_compactor (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .walk       (walk),
      .rd_seq     (rd_seq),
      .rd_payload (rd_payload)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      replay_in    = replay_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      out_seq_in   = out_seq_ff;
      out_pay_in   = out_pay_ff;
      out_held_in  = out_held_ff;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  asrb_pkg::OP_PUSH: begin
                     cmd.push          = 1'b1;
                     cmd.addr          = head_ff;
                     cmd.entry.seq     = req_tdata[15:0];
                     cmd.entry.payload = req_tdata[47:16];
                     head_in           = head_ff + 1'b1;
                     if (count_ff != asrb_pkg::CNT_W'(asrb_pkg::DEPTH)) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  asrb_pkg::OP_DROP, asrb_pkg::OP_REPLAY: begin
                     if (count_ff != '0) begin
                        cmd.drop  = 1'b1;
                        cmd.addr  = start;
                        cmd.count = count_ff;
                        cmd.ack   = req_tdata[63:48];
                        replay_in = (req_tuser == asrb_pkg::OP_REPLAY);
                        state_in  = ST_DROP;
                     end
                  end
                  default: begin
                  end
               endcase
               // status result unless a walk was started
               if (!cmd.drop) begin
                  out_valid_in = 1'b1;
                  out_user_in  = 1'b0;
                  out_last_in  = 1'b1;
                  out_seq_in   = '0;
                  out_pay_in   = '0;
                  out_held_in  = asrb_pkg::HELD_W'(count_in);
               end
            end
         end
         ST_DROP: begin
            if (walk.done) begin
               count_in = walk.kept;
               head_in  = start + walk.kept[asrb_pkg::IDX_W-1:0];
               idx_in   = '0;
               state_in = (replay_ff && walk.kept != '0) ? ST_READ : ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_user_in  = 1'b0;
               out_last_in  = 1'b1;
               out_seq_in   = '0;
               out_pay_in   = '0;
               out_held_in  = asrb_pkg::HELD_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            cmd.addr = start + idx_ff[asrb_pkg::IDX_W-1:0];
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_user_in  = 1'b1;
               out_last_in  = last_entry;
               out_seq_in   = rd_seq;
               out_pay_in   = rd_payload;
               out_held_in  = asrb_pkg::HELD_W'(count_ff);
               idx_in       = idx_ff + 1'b1;
               state_in     = last_entry ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      replay_ff   <= replay_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
      out_seq_ff  <= out_seq_in;
      out_pay_ff  <= out_pay_in;
      out_held_ff <= out_held_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_held_ff, out_pay_ff, out_seq_ff};

   // held count never exceeds the ring depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= asrb_pkg::CNT_W'(asrb_pkg::DEPTH))
      else $error("held count beyond ring depth");

   // the walker only reports completion while the sequencer waits for it
   a_done_in_drop: assert property (@(posedge clock) disable iff (reset)
      walk.done |-> state_ff == ST_DROP)
      else $error("drop walk finished outside drop state");

   // a status result always closes its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("status result without last");

   // no request is taken while the walker is busy
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      walk.busy |-> !req_tready)
      else $error("request accepted during drop walk");

endmodule

FILE: hw/rtl/asrb_compactor.sv
// ----------------------------------------------------------------------------
// asrb_compactor: entry store and drop walker
// Holds the ring entries. A drop walks the held entries oldest first, one a
// cycle through a single serial compare, and packs the kept ones behind it.
// ----------------------------------------------------------------------------
module asrb_compactor (
   input  logic                           clock,
   input  logic                           reset,
   input  asrb_pkg::cmd_type              cmd,
   output asrb_pkg::walk_type             walk,
   output logic [asrb_pkg::SEQ_W-1:0]        rd_seq,
   output logic [asrb_pkg::PAYLOAD_BITS-1:0] rd_payload
);

   asrb_pkg::entry_type mem [asrb_pkg::DEPTH];
   asrb_pkg::entry_type rdata_ff;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       pend_ff, pend_in;
   logic [asrb_pkg::IDX_W-1:0] start_ff, start_in;
   logic [asrb_pkg::CNT_W-1:0] n_ff, n_in;
   logic [asrb_pkg::CNT_W-1:0] rd_off_ff, rd_off_in;
   logic [asrb_pkg::CNT_W-1:0] kept_ff, kept_in;
   logic [asrb_pkg::SEQ_W-1:0] ack_ff, ack_in;

   logic                       more;
   logic                       keep;
   logic [asrb_pkg::SEQ_W-1:0] diff;
   logic                       rd_en, wr_en;
   logic [asrb_pkg::IDX_W-1:0] raddr, waddr;
   asrb_pkg::entry_type        wdata;

   // serial number difference: keep only strictly positive
   assign diff = rdata_ff.seq - ack_ff;
   assign keep = (diff != '0) && !diff[asrb_pkg::SEQ_W-1];
   assign more = busy_ff && (rd_off_ff != n_ff);

   // kept entries are written behind the read pointer in ring order, so a
   // write never lands on an entry still to be read
   always_comb begin
      rd_en = more || cmd.read;
      raddr = busy_ff ? start_ff + rd_off_ff[asrb_pkg::IDX_W-1:0] : cmd.addr;
      wr_en = cmd.push || (pend_ff && keep);
      waddr = cmd.push ? cmd.addr : start_ff + kept_ff[asrb_pkg::IDX_W-1:0];
      wdata = cmd.push ? cmd.entry : rdata_ff;
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      pend_in   = more;
      start_in  = start_ff;
      n_in      = n_ff;
      ack_in    = ack_ff;
      rd_off_in = more ? rd_off_ff + 1'b1 : rd_off_ff;
      kept_in   = (pend_ff && keep) ? kept_ff + 1'b1 : kept_ff;
      if (cmd.drop) begin
         busy_in   = 1'b1;
         pend_in   = 1'b0;
         start_in  = cmd.addr;
         n_in      = cmd.count;
         ack_in    = cmd.ack;
         rd_off_in = '0;
         kept_in   = '0;
      end else if (busy_ff && !more && !pend_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pend_ff <= pend_in;
      end
      start_ff  <= start_in;
      n_ff      <= n_in;
      ack_ff    <= ack_in;
      rd_off_ff <= rd_off_in;
      kept_ff   <= kept_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign walk.busy  = busy_ff;
   assign walk.done  = done_ff;
   assign walk.kept  = kept_ff;
   assign rd_seq     = rdata_ff.seq;
   assign rd_payload = rdata_ff.payload;

endmodule
